// ----- hdl/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define DTQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// signal holds its value from one edge to the next under a condition
`define DTQ_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("assertion failed");

`endif

// ----- hdl/dtq_pkg.sv -----
package dtq_pkg;

    // most results one input transaction may cause
    localparam int MAX_RESULTS = 16;
    localparam int RES_BITS    = 5;

    // operation codes on the func field
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // result kinds
    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_ADDED     = 3'd1,
        KIND_DELETED   = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_FULL      = 3'd4,
        KIND_NO_FIRE   = 3'd5
    } t_kind;

    // decoded command handed from the front to the engine
    typedef struct packed {
        t_op         op;
        logic [23:0] period_ticks;
        logic [15:0] repeat_count;
        logic [15:0] target_id;
    } t_cmd;

endpackage

// ----- hdl/dtq_if.sv -----
interface dtq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [23:0] period_ticks;
    logic [15:0] repeat_count;
    logic [15:0] target_id;

    modport source (output valid, func, period_ticks, repeat_count, target_id, input ready);
    modport sink   (input valid, func, period_ticks, repeat_count, target_id, output ready);
endinterface

interface dtq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] timer_id;
    logic        final_fire;
    logic [23:0] next_due;
    logic        queue_empty;
    logic        last;

    modport source (output valid, kind, timer_id, final_fire, next_due, queue_empty, last,
                    input ready);
    modport sink   (input valid, kind, timer_id, final_fire, next_due, queue_empty, last,
                    output ready);
endinterface

// ----- hdl/dtq_front.sv -----
module dtq_front
    import dtq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dtq_in_if.sink i_req,
    output logic   o_cmd_valid,
    input  logic   i_cmd_ready,
    output t_cmd   o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop, keep;
    t_cmd       dec;

    // decode the incoming transaction
    always_comb begin
        dec.op           = t_op'(i_req.func);
        dec.period_ticks = i_req.period_ticks;
        dec.repeat_count = i_req.repeat_count;
        dec.target_id    = i_req.target_id;
    end

    // unused operation code is taken and dropped
    assign keep        = (dec.op != OP_NONE);
    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // two-deep command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= dec;
    end

endmodule

// ----- hdl/dtq_engine.sv -----
module dtq_engine
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    dtq_out_if.source  o_rsp
);

    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int IW = $clog2(NUM_TIMERS);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_ADD_WALK = 6'b000010,
        S_DEL_WALK = 6'b000100,
        S_POP      = 6'b001000,
        S_EMIT     = 6'b010000,
        S_SPARE    = 6'b100000
    } t_state;

    // timer table, packed in queue order
    logic [15:0]          r_id_a  [NUM_TIMERS];
    logic [TICK_BITS-1:0] r_rem_a [NUM_TIMERS];
    logic [TICK_BITS-1:0] r_per_a [NUM_TIMERS];
    logic [15:0]          r_fir_a [NUM_TIMERS];
    logic [15:0]          n_id_a  [NUM_TIMERS];
    logic [TICK_BITS-1:0] n_rem_a [NUM_TIMERS];
    logic [TICK_BITS-1:0] n_per_a [NUM_TIMERS];
    logic [15:0]          n_fir_a [NUM_TIMERS];

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_pos, n_pos;
    logic [15:0]          r_next_id, n_next_id;
    logic [TICK_BITS-1:0] r_walk, n_walk;
    logic [15:0]          r_cur_id, n_cur_id;
    logic [TICK_BITS-1:0] r_cur_per, n_cur_per;
    logic [15:0]          r_cur_fir, n_cur_fir;
    logic [RES_BITS-1:0]  r_k, n_k;
    t_kind                r_res_kind, n_res_kind;
    logic [15:0]          r_res_id, n_res_id;
    logic                 r_res_fin, n_res_fin;

    // output register
    logic                 r_ov, n_ov;
    t_kind                r_o_kind, n_o_kind;
    logic [15:0]          r_o_id, n_o_id;
    logic                 r_o_fin, n_o_fin;
    logic [23:0]          r_o_due, n_o_due;
    logic                 r_o_empty, n_o_empty;
    logic                 r_o_last, n_o_last;

    logic [IW-1:0]        pos_idx;
    logic                 pos_in;
    logic [TICK_BITS-1:0] rd_rem;
    logic [15:0]          rd_id;
    logic [TICK_BITS-1:0] p_raw, p_fix;
    logic [TICK_BITS:0]   sat_sum;
    logic [TICK_BITS-1:0] sat_val;
    logic                 more;

    assign pos_idx = r_pos[IW-1:0];
    assign pos_in  = (r_pos < r_count);
    assign rd_rem  = r_rem_a[pos_idx];
    assign rd_id   = r_id_a[pos_idx];
    assign p_raw   = TICK_BITS'(i_cmd.period_ticks);
    assign p_fix   = (p_raw == '0) ? TICK_BITS'(1) : p_raw;

    // successor absorbs the delay of a deleted entry
    always_comb begin
        sat_sum = '0;
        for (int i = 0; i < NUM_TIMERS - 1; i++) begin
            if (CW'(i) == r_pos)
                sat_sum = {1'b0, r_rem_a[i + 1]} + {1'b0, r_rem_a[i]};
        end
        sat_val = sat_sum[TICK_BITS] ? '1 : sat_sum[TICK_BITS-1:0];
    end

    // another fire is pending after this result
    assign more = (r_res_kind == KIND_FIRED) && ((r_k + 1'b1) < RES_BITS'(MAX_RESULTS))
                  && (r_count != '0) && (r_rem_a[0] == '0);

    assign o_cmd_ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_id_a     = r_id_a;
        n_rem_a    = r_rem_a;
        n_per_a    = r_per_a;
        n_fir_a    = r_fir_a;
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_next_id  = r_next_id;
        n_walk     = r_walk;
        n_cur_id   = r_cur_id;
        n_cur_per  = r_cur_per;
        n_cur_fir  = r_cur_fir;
        n_k        = r_k;
        n_res_kind = r_res_kind;
        n_res_id   = r_res_id;
        n_res_fin  = r_res_fin;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_kind   = r_o_kind;
        n_o_id     = r_o_id;
        n_o_fin    = r_o_fin;
        n_o_due    = r_o_due;
        n_o_empty  = r_o_empty;
        n_o_last   = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_k       = '0;
                    n_res_fin = 1'b0;
                    n_pos     = '0;
                    case (i_cmd.op)
                        OP_ADD: begin
                            if (r_count == CW'(NUM_TIMERS)) begin
                                n_res_kind = KIND_FULL;
                                n_res_id   = '0;
                                n_state    = S_EMIT;
                            end else begin
                                n_cur_id   = r_next_id;
                                n_next_id  = r_next_id + 16'd1;
                                n_cur_per  = p_fix;
                                n_cur_fir  = i_cmd.repeat_count;
                                n_walk     = p_fix;
                                n_res_kind = KIND_ADDED;
                                n_res_id   = r_next_id;
                                n_state    = S_ADD_WALK;
                            end
                        end
                        OP_DEL: begin
                            n_cur_id = i_cmd.target_id;
                            n_state  = S_DEL_WALK;
                        end
                        OP_TICK: begin
                            n_res_kind = KIND_NO_FIRE;
                            n_res_id   = '0;
                            if (r_count == '0) begin
                                n_state = S_EMIT;
                            end else if (r_rem_a[0] > TICK_BITS'(1)) begin
                                n_rem_a[0] = r_rem_a[0] - TICK_BITS'(1);
                                n_state    = S_EMIT;
                            end else begin
                                n_rem_a[0] = '0;
                                n_state    = S_POP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // walk the delta list, insert ahead of equal deadlines
            S_ADD_WALK: begin
                if (!pos_in || (r_walk <= rd_rem)) begin
                    for (int i = 1; i < NUM_TIMERS; i++) begin
                        if (CW'(i) > r_pos && CW'(i) <= r_count) begin
                            n_id_a[i]  = r_id_a[i - 1];
                            n_per_a[i] = r_per_a[i - 1];
                            n_fir_a[i] = r_fir_a[i - 1];
                            n_rem_a[i] = (CW'(i) == r_pos + 1'b1) ?
                                         r_rem_a[i - 1] - r_walk : r_rem_a[i - 1];
                        end
                    end
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (CW'(i) == r_pos) begin
                            n_id_a[i]  = r_cur_id;
                            n_per_a[i] = r_cur_per;
                            n_fir_a[i] = r_cur_fir;
                            n_rem_a[i] = r_walk;
                        end
                    end
                    n_count = r_count + 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_walk = r_walk - rd_rem;
                    n_pos  = r_pos + 1'b1;
                end
            end

            // search by identifier, close the gap on a hit
            S_DEL_WALK: begin
                n_res_id = r_cur_id;
                if (!pos_in) begin
                    n_res_kind = KIND_NOT_FOUND;
                    n_state    = S_EMIT;
                end else if (rd_id == r_cur_id) begin
                    for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                        if (CW'(i) >= r_pos && CW'(i + 1) < r_count) begin
                            n_id_a[i]  = r_id_a[i + 1];
                            n_per_a[i] = r_per_a[i + 1];
                            n_fir_a[i] = r_fir_a[i + 1];
                            n_rem_a[i] = (CW'(i) == r_pos) ? sat_val : r_rem_a[i + 1];
                        end
                    end
                    n_count    = r_count - 1'b1;
                    n_res_kind = KIND_DELETED;
                    n_state    = S_EMIT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end

            // fire the head, re-queue it if fires remain
            S_POP: begin
                for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                    if (CW'(i + 1) < r_count) begin
                        n_id_a[i]  = r_id_a[i + 1];
                        n_per_a[i] = r_per_a[i + 1];
                        n_fir_a[i] = r_fir_a[i + 1];
                        n_rem_a[i] = r_rem_a[i + 1];
                    end
                end
                n_count    = r_count - 1'b1;
                n_res_kind = KIND_FIRED;
                n_res_id   = r_id_a[0];
                n_res_fin  = (r_fir_a[0] == 16'd1);
                if (r_fir_a[0] == 16'd1) begin
                    n_state = S_EMIT;
                end else begin
                    n_cur_id  = r_id_a[0];
                    n_cur_per = r_per_a[0];
                    n_cur_fir = (r_fir_a[0] == 16'd0) ? 16'd0 : r_fir_a[0] - 16'd1;
                    n_walk    = r_per_a[0];
                    n_pos     = '0;
                    n_state   = S_ADD_WALK;
                end
            end

            // load the output register once it is free
            S_EMIT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov      = 1'b1;
                    n_o_kind  = r_res_kind;
                    n_o_id    = r_res_id;
                    n_o_fin   = r_res_fin;
                    n_o_due   = (r_count == '0) ? 24'd0 : 24'(r_rem_a[0]);
                    n_o_empty = (r_count == '0);
                    n_o_last  = !more;
                    if (more) begin
                        n_k     = r_k + 1'b1;
                        n_state = S_POP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_ov      <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_id_a     <= n_id_a;
        r_rem_a    <= n_rem_a;
        r_per_a    <= n_per_a;
        r_fir_a    <= n_fir_a;
        r_pos      <= n_pos;
        r_walk     <= n_walk;
        r_cur_id   <= n_cur_id;
        r_cur_per  <= n_cur_per;
        r_cur_fir  <= n_cur_fir;
        r_k        <= n_k;
        r_res_kind <= n_res_kind;
        r_res_id   <= n_res_id;
        r_res_fin  <= n_res_fin;
        r_o_kind   <= n_o_kind;
        r_o_id     <= n_o_id;
        r_o_fin    <= n_o_fin;
        r_o_due    <= n_o_due;
        r_o_empty  <= n_o_empty;
        r_o_last   <= n_o_last;
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.kind        = r_o_kind;
    assign o_rsp.timer_id    = r_o_id;
    assign o_rsp.final_fire  = r_o_fin;
    assign o_rsp.next_due    = r_o_due;
    assign o_rsp.queue_empty = r_o_empty;
    assign o_rsp.last        = r_o_last;

endmodule

// ----- hdl/delta_timer_queue.sv -----
// add: a full table reports at once, else the table is walked entry by entry to the insertion point
// delete: the table is walked to a hit; a miss walks every entry and one step past the end
// tick: without a fire the head delay counts down; each fire pops the head and re-queues it if fires remain
// throughput: one transaction at a time in the engine; a two-deep queue takes new ones
// the sorted walk over the timer table sets the rate, one entry per cycle
// reset: synchronous active low, table empties and identifier counter returns to zero
module delta_timer_queue
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtq_in_if.sink    i_req,
    dtq_out_if.source o_rsp
);

    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    // front: accept and decode
    dtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back: table walk and results
    dtq_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_BITS  (TICK_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- hdl/dtq_checker.sv -----
`include "assert_macros.svh"

module dtq_checker
    import dtq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_kind,
    input logic [15:0] i_timer_id,
    input logic        i_final_fire,
    input logic [23:0] i_next_due,
    input logic        i_queue_empty,
    input logic        i_last
);

    // a stalled result holds its kind, identifier and last flag
    `DTQ_ASSERT_HOLD(a_hold, i_clk, i_rst_n, i_valid && !i_ready, {i_kind, i_timer_id, i_last})

    // an empty queue reports no pending delay
    `DTQ_ASSERT_IMPLY(a_empty_due, i_clk, i_rst_n, i_valid && i_queue_empty, i_next_due == 24'd0)

    // only a fire may drop a timer
    `DTQ_ASSERT_IMPLY(a_fin_kind, i_clk, i_rst_n, i_valid && i_final_fire, i_kind == KIND_FIRED)

    // every other result closes its transaction
    `DTQ_ASSERT_IMPLY(a_single, i_clk, i_rst_n, i_valid && i_kind != KIND_FIRED, i_last)

endmodule

bind delta_timer_queue dtq_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_kind        (o_rsp.kind),
    .i_timer_id    (o_rsp.timer_id),
    .i_final_fire  (o_rsp.final_fire),
    .i_next_due    (o_rsp.next_due),
    .i_queue_empty (o_rsp.queue_empty),
    .i_last        (o_rsp.last)
);
